/* design/bracket_balance_checker_core_assert.svh */
// Assertion macros shared by the bracket checker RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef BRACKET_BALANCE_CHECKER_CORE_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket checker: next-cycle check failed");

`endif

/* design/bbc_pkg.sv */
// Shared types, constants and character decode functions for the bracket checker.
// No dependencies; every other design file but the assertion header refers to it by scoped names.
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int MAX_POSITION = 4095;
    localparam int COUNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int POS_W        = 12;
    localparam int CHAR_W       = 8;

    typedef logic [CHAR_W-1:0]  byte_t;
    typedef logic [1:0]         kind_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [POS_W-1:0]   pos_t;

    localparam byte_t CH_LPAREN = 8'h28;
    localparam byte_t CH_RPAREN = 8'h29;
    localparam byte_t CH_LBRACE = 8'h7B;
    localparam byte_t CH_RBRACE = 8'h7D;
    localparam byte_t CH_LBRACK = 8'h5B;
    localparam byte_t CH_RBRACK = 8'h5D;
    localparam byte_t CH_LANGLE = 8'h3C;
    localparam byte_t CH_RANGLE = 8'h3E;

    localparam kind_t KIND_PAREN = 2'd0;
    localparam kind_t KIND_BRACE = 2'd1;
    localparam kind_t KIND_BRACK = 2'd2;
    localparam kind_t KIND_ANGLE = 2'd3;

    typedef enum logic [2:0] {
        ST_BALANCED      = 3'd0,
        ST_EXPECTING     = 3'd1,
        ST_MISSING_OPEN  = 3'd2,
        ST_MISSING_CLOSE = 3'd3,
        ST_OVERFLOW      = 3'd4
    } status_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } decode_t;

    // Stack operation broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    typedef struct packed {
        status_t status;
        pos_t    position;
        byte_t   symbol;
    } result_t;

    function automatic decode_t open_kind(input byte_t c);
        decode_t d;
        d.hit  = 1'b1;
        d.kind = KIND_PAREN;
        unique case (c)
            CH_LPAREN: d.kind = KIND_PAREN;
            CH_LBRACE: d.kind = KIND_BRACE;
            CH_LBRACK: d.kind = KIND_BRACK;
            CH_LANGLE: d.kind = KIND_ANGLE;
            default:   d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    function automatic decode_t close_kind(input byte_t c);
        decode_t d;
        d.hit  = 1'b1;
        d.kind = KIND_PAREN;
        unique case (c)
            CH_RPAREN: d.kind = KIND_PAREN;
            CH_RBRACE: d.kind = KIND_BRACE;
            CH_RBRACK: d.kind = KIND_BRACK;
            CH_RANGLE: d.kind = KIND_ANGLE;
            default:   d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    function automatic byte_t open_char(input kind_t k);
        byte_t c;
        unique case (k)
            KIND_PAREN: c = CH_LPAREN;
            KIND_BRACE: c = CH_LBRACE;
            KIND_BRACK: c = CH_LBRACK;
            default:    c = CH_LANGLE;
        endcase
        return c;
    endfunction

    function automatic byte_t close_char(input kind_t k);
        byte_t c;
        unique case (k)
            KIND_PAREN: c = CH_RPAREN;
            KIND_BRACE: c = CH_RBRACE;
            KIND_BRACK: c = CH_RBRACK;
            default:    c = CH_RANGLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/bbc_if.sv */
// Valid/ready channel interfaces for the character input and the result output.
// Depends on bbc_pkg for field types.
`default_nettype none

interface bbc_char_if;
    logic          valid;
    logic          ready;
    bbc_pkg::byte_t char_code;
    logic          line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface bbc_result_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    bbc_pkg::pos_t     position;
    bbc_pkg::byte_t    symbol;

    modport source (output valid, output status, output position, output symbol, input ready);
    modport sink (input valid, input status, input position, input symbol, output ready);
endinterface

`default_nettype wire

/* design/bbc_cell.sv */
// One entry of the shifting bracket stack; cell 0 holds the top of stack.
// Depends on bbc_pkg for the kind and stack operation types.
`default_nettype none

module bbc_cell (
    input  wire logic              clk,
    input  wire bbc_pkg::stack_op_t op,
    input  wire bbc_pkg::kind_t    from_above,
    input  wire bbc_pkg::kind_t    from_below,
    output bbc_pkg::kind_t         kind
);

    bbc_pkg::kind_t kind_reg;
    bbc_pkg::kind_t kind_next;

    // A push moves every entry one cell deeper; a pop moves them one cell up.
    always_comb
    begin
        priority if (op.push)
        begin
            kind_next = from_above;
        end
        else if (op.pop)
        begin
            kind_next = from_below;
        end
        else
        begin
            kind_next = kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

`default_nettype wire

/* design/bracket_balance_checker_core.sv */
// Results are registered in the output register, or in the skid entry when it stalls.
// Throughput: one character or line end per cycle while the skid entry is empty; the
// match reads only cell 0 of a 64-cell shift chain; push and pop shift every cell.
// A two-entry output buffer keeps input beats flowing while one result is stalled.
// Reset clears the depth count, position, error flag and output valids; stack cells
// are not reset and are only read below the depth count.
`default_nettype none
`include "bracket_balance_checker_core_assert.svh"

module bracket_balance_checker_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bbc_char_if.sink      chars,
    bbc_result_if.source  results
);

    localparam int DEPTH = bbc_pkg::STACK_DEPTH;

    bbc_pkg::count_t   count_reg, count_next;
    bbc_pkg::pos_t     pos_reg, pos_next;
    logic              err_reg, err_next;

    bbc_pkg::kind_t    cell_kind [DEPTH];
    bbc_pkg::stack_op_t op;
    bbc_pkg::decode_t  ok, ck;
    bbc_pkg::kind_t    top;
    logic              in_fire;
    logic              res_valid;
    bbc_pkg::result_t  res;

    logic              out_valid_reg, out_valid_next;
    bbc_pkg::result_t  out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    bbc_pkg::result_t  skid_data_reg, skid_data_next;
    logic              out_take;

    // Stack chain.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bbc_pkg::kind_t above, below;
        if (i == 0)
        begin : g_top
            assign above = ok.kind;
        end
        else
        begin : g_mid
            assign above = cell_kind[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign below = cell_kind[i];
        end
        else
        begin : g_inner
            assign below = cell_kind[i+1];
        end
        bbc_cell u_cell (
            .clk        (clk),
            .op         (op),
            .from_above (above),
            .from_below (below),
            .kind       (cell_kind[i])
        );
    end

    assign top     = cell_kind[0];
    assign ok      = bbc_pkg::open_kind(chars.char_code);
    assign ck      = bbc_pkg::close_kind(chars.char_code);
    assign in_fire = chars.valid && chars.ready;

    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        err_next        = err_reg;
        op              = '0;
        res_valid       = 1'b0;
        res.status      = bbc_pkg::ST_BALANCED;
        res.position    = pos_reg;
        res.symbol      = '0;
        if (in_fire)
        begin
            if (chars.line_end)
            begin
                count_next = '0;
                pos_next   = '0;
                err_next   = 1'b0;
                if (!err_reg)
                begin
                    res_valid = 1'b1;
                    if (count_reg != '0)
                    begin
                        res.status = bbc_pkg::ST_MISSING_CLOSE;
                        res.symbol = bbc_pkg::close_char(top);
                    end
                end
            end
            else if (!err_reg)
            begin
                if (pos_reg != bbc_pkg::POS_W'(bbc_pkg::MAX_POSITION))
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if (ok.hit)
                begin
                    if (count_reg == bbc_pkg::COUNT_W'(DEPTH))
                    begin
                        err_next   = 1'b1;
                        res_valid  = 1'b1;
                        res.status = bbc_pkg::ST_OVERFLOW;
                        res.symbol = chars.char_code;
                    end
                    else
                    begin
                        op.push    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (ck.hit)
                begin
                    if (count_reg == '0)
                    begin
                        err_next   = 1'b1;
                        res_valid  = 1'b1;
                        res.status = bbc_pkg::ST_MISSING_OPEN;
                        res.symbol = bbc_pkg::open_char(ck.kind);
                    end
                    else if (top == ck.kind)
                    begin
                        op.pop     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        res_valid  = 1'b1;
                        res.status = bbc_pkg::ST_EXPECTING;
                        res.symbol = bbc_pkg::close_char(top);
                    end
                end
            end
        end
    end

    // Output register plus skid entry; input stalls only when both are full.
    assign chars.ready = !skid_valid_reg;
    assign out_take    = out_valid_reg && results.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pos_reg        <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.status   = out_data_reg.status;
    assign results.position = out_data_reg.position;
    assign results.symbol   = out_data_reg.symbol;

    `BBC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= bbc_pkg::COUNT_W'(DEPTH))
    `BBC_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `BBC_ASSERT_IMPL(a_quiet_after_error, in_fire && err_reg && !chars.line_end, !res_valid)
    `BBC_ASSERT_NEXT(a_line_end_clears, in_fire && chars.line_end, count_reg == '0 && pos_reg == '0 && !err_reg)

endmodule

`default_nettype wire

/* tb/sv/tb_bracket_balance_checker_core.sv */
// Self-checking testbench for bracket_balance_checker_core: a directed table, long lines for
// stack overflow and position saturation, then random lines with idling on both channels.
// Depends on bbc_pkg, the channel interfaces in bbc_if.sv and the core RTL.
`default_nettype none

module tb_bracket_balance_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        bbc_pkg::byte_t   ch;
        logic             le;
        bit               fixed;
        bbc_pkg::result_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bbc_char_if   char_ch ();
    bbc_result_if res_ch ();

    bracket_balance_checker_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_ch),
        .results (res_ch)
    );

    bbc_pkg::byte_t openers [4] = '{bbc_pkg::CH_LPAREN, bbc_pkg::CH_LBRACE,
                                    bbc_pkg::CH_LBRACK, bbc_pkg::CH_LANGLE};
    bbc_pkg::byte_t closers [4] = '{bbc_pkg::CH_RPAREN, bbc_pkg::CH_RBRACE,
                                    bbc_pkg::CH_RBRACK, bbc_pkg::CH_RANGLE};

    // Shadow copy of the line state.
    bbc_pkg::kind_t stack_mem [bbc_pkg::STACK_DEPTH];
    int    depth_cnt = 0;
    int    line_pos  = 0;
    bit    line_err  = 1'b0;

    bbc_pkg::result_t pending_results [$];
    int      mismatches    = 0;
    int      counted_beats = 0;
    int      idle_cycles   = 0;

    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Mostly back-to-back, sometimes a short gap, rarely a long pause; calm callers never pause.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bbc_pkg::byte_t pick_filler();
        bbc_pkg::byte_t c;
        bit    hit;
        do
        begin
            c   = bbc_pkg::byte_t'($urandom_range(0, 255));
            hit = 1'b0;
            for (int k = 0; k < 4; k++)
                if (c == openers[k] || c == closers[k])
                    hit = 1'b1;
        end
        while (hit);
        return c;
    endfunction

    function automatic step_row_t row(input bbc_pkg::byte_t ch, input logic le,
                                      input bit fixed = 1'b0,
                                      input bbc_pkg::status_t st = bbc_pkg::ST_BALANCED,
                                      input int p = 0,
                                      input bbc_pkg::byte_t sym = 8'h00);
        step_row_t r;
        r.ch            = ch;
        r.le            = le;
        r.fixed         = fixed;
        r.want.status   = st;
        r.want.position = bbc_pkg::pos_t'(p);
        r.want.symbol   = sym;
        return r;
    endfunction

    // Advances the shadow line state by one beat; returns 1 when the beat yields a result.
    function automatic bit track_line_step(input bbc_pkg::byte_t c, input logic le,
                                           output bbc_pkg::result_t r);
        int   ko;
        int   kc;
        bit   got;
        bbc_pkg::pos_t p;
        ko  = -1;
        kc  = -1;
        got = 1'b0;
        p   = bbc_pkg::pos_t'(line_pos);
        r   = '0;
        if (le)
        begin
            if (!line_err)
            begin
                got        = 1'b1;
                r.position = p;
                if (depth_cnt == 0)
                    r.status = bbc_pkg::ST_BALANCED;
                else
                begin
                    r.status = bbc_pkg::ST_MISSING_CLOSE;
                    r.symbol = closers[stack_mem[depth_cnt-1]];
                end
            end
            depth_cnt = 0;
            line_pos  = 0;
            line_err  = 1'b0;
            return got;
        end
        if (line_err)
            return 1'b0;
        if (line_pos < bbc_pkg::MAX_POSITION)
            line_pos++;
        for (int k = 0; k < 4; k++)
        begin
            if (c == openers[k])
                ko = k;
            if (c == closers[k])
                kc = k;
        end
        r.position = p;
        if (ko >= 0)
        begin
            if (depth_cnt >= bbc_pkg::STACK_DEPTH)
            begin
                line_err = 1'b1;
                r.status = bbc_pkg::ST_OVERFLOW;
                r.symbol = c;
                return 1'b1;
            end
            stack_mem[depth_cnt] = bbc_pkg::kind_t'(ko);
            depth_cnt++;
            return 1'b0;
        end
        if (kc >= 0)
        begin
            if (depth_cnt == 0)
            begin
                line_err = 1'b1;
                r.status = bbc_pkg::ST_MISSING_OPEN;
                r.symbol = openers[kc];
                return 1'b1;
            end
            if (stack_mem[depth_cnt-1] == bbc_pkg::kind_t'(kc))
            begin
                depth_cnt--;
                return 1'b0;
            end
            line_err = 1'b1;
            r.status = bbc_pkg::ST_EXPECTING;
            r.symbol = closers[stack_mem[depth_cnt-1]];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Drives one beat, waits for it to be taken and records what it should produce.
    task automatic push_char(input bbc_pkg::byte_t c, input logic le, input bit calm,
                             input bit fixed = 1'b0, input bbc_pkg::result_t want = '0);
        int      gap;
        bit      has;
        bbc_pkg::result_t got;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.line_end  <= le;
        do
            @(posedge clk);
        while (char_ch.ready !== 1'b1);
        // Bytes swallowed after an error do not count toward the item budget.
        if (le || !line_err)
            counted_beats++;
        has = track_line_step(c, le, got);
        if (fixed)
            pending_results.push_back(want);
        else if (has)
            pending_results.push_back(got);
    endtask

    task automatic send_random_line();
        bbc_pkg::kind_t open_q [$];
        bbc_pkg::kind_t k;
        bbc_pkg::byte_t nc;
        int    mode;
        int    cap;
        int    len;
        int    r;
        bit    calm;
        mode = $urandom_range(0, 99);
        calm = ($urandom_range(0, 3) == 0);
        cap  = ($urandom_range(0, 15) == 0)
               ? $urandom_range(bbc_pkg::STACK_DEPTH - 3, bbc_pkg::STACK_DEPTH + 3)
               : $urandom_range(1, 8);
        len  = $urandom_range(0, 16);
        if (mode < 10)
        begin
            repeat (len)
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    nc = openers[$urandom_range(0, 3)];
                else if (r == 1)
                    nc = closers[$urandom_range(0, 3)];
                else
                    nc = bbc_pkg::byte_t'($urandom_range(0, 255));
                push_char(nc, 1'b0, calm);
            end
        end
        else
        begin
            // Deep lines first push openers to just below, at, or just past the stack depth.
            if (cap > 8)
            begin
                repeat (cap)
                begin
                    k = bbc_pkg::kind_t'($urandom_range(0, 3));
                    open_q.push_back(k);
                    push_char(openers[k], 1'b0, calm);
                end
            end
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < 40 && open_q.size() < cap)
                begin
                    k = bbc_pkg::kind_t'($urandom_range(0, 3));
                    open_q.push_back(k);
                    push_char(openers[k], 1'b0, calm);
                end
                else if (r < 75 && open_q.size() > 0)
                begin
                    k = open_q.pop_back();
                    push_char(closers[k], 1'b0, calm);
                end
                else
                    push_char(pick_filler(), 1'b0, calm);
            end
            if (mode < 65)
            begin
                while (open_q.size() > 0)
                begin
                    k = open_q.pop_back();
                    push_char(closers[k], 1'b0, calm);
                end
            end
            else if (mode >= 85)
            begin
                // A closer of the wrong kind, or a stray one when nothing is open.
                k = bbc_pkg::kind_t'($urandom_range(0, 3));
                if (open_q.size() > 0 && k == open_q[$])
                    k = k + 2'd1;
                push_char(closers[k], 1'b0, calm);
                repeat ($urandom_range(0, 3))
                    push_char(bbc_pkg::byte_t'($urandom_range(0, 255)), 1'b0, calm);
            end
        end
        push_char(bbc_pkg::byte_t'($urandom_range(0, 255)), 1'b1, calm);
    endtask

    // Result side: random stalls with occasional long stretches of steady ready.
    initial
    begin
        int n;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = pick_gap(1'b0);
            if (n > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        bbc_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report($sformatf("unexpected result status=%0d position=%0d symbol=%h",
                                 res_ch.status, res_ch.position, res_ch.symbol));
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status)
                    report($sformatf("status %0d, expected %0d", res_ch.status, want.status));
                if (res_ch.position !== want.position)
                    report($sformatf("position %0d, expected %0d",
                                     res_ch.position, want.position));
                if (res_ch.symbol !== want.symbol)
                    report($sformatf("symbol %h, expected %h", res_ch.symbol, want.symbol));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a beat", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        step_row_t dir_rows [$];
        int        start;
        rst_n             <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= 8'h00;
        char_ch.line_end  <= 1'b0;

        // Every byte here is a beat; rows with a typed result carry their own expectation.
        dir_rows.push_back(row(8'h00, 1'b1, 1'b1, bbc_pkg::ST_BALANCED, 0, 8'h00));
        dir_rows.push_back(row(bbc_pkg::CH_RPAREN, 1'b0, 1'b1, bbc_pkg::ST_MISSING_OPEN, 0,
                               bbc_pkg::CH_LPAREN));
        dir_rows.push_back(row(8'h78, 1'b0));
        dir_rows.push_back(row(8'hFF, 1'b1));
        dir_rows.push_back(row(bbc_pkg::CH_LPAREN, 1'b0));
        dir_rows.push_back(row(bbc_pkg::CH_LBRACK, 1'b0));
        dir_rows.push_back(row(bbc_pkg::CH_RBRACE, 1'b0, 1'b1, bbc_pkg::ST_EXPECTING, 2,
                               bbc_pkg::CH_RBRACK));
        dir_rows.push_back(row(8'h00, 1'b1));
        dir_rows.push_back(row(bbc_pkg::CH_LBRACE, 1'b0));
        dir_rows.push_back(row(bbc_pkg::CH_LANGLE, 1'b0));
        dir_rows.push_back(row(8'h00, 1'b0));
        dir_rows.push_back(row(8'hFF, 1'b0));
        dir_rows.push_back(row(bbc_pkg::CH_RANGLE, 1'b0));
        dir_rows.push_back(row(bbc_pkg::CH_RBRACE, 1'b0));
        dir_rows.push_back(row(8'h55, 1'b1, 1'b1, bbc_pkg::ST_BALANCED, 6, 8'h00));
        dir_rows.push_back(row(bbc_pkg::CH_LANGLE, 1'b0));
        dir_rows.push_back(row(8'hAA, 1'b1, 1'b1, bbc_pkg::ST_MISSING_CLOSE, 1,
                               bbc_pkg::CH_RANGLE));
        dir_rows.push_back(row(bbc_pkg::CH_RBRACK, 1'b0, 1'b1, bbc_pkg::ST_MISSING_OPEN, 0,
                               bbc_pkg::CH_LBRACK));
        dir_rows.push_back(row(8'h00, 1'b1));
        dir_rows.push_back(row(bbc_pkg::CH_RANGLE, 1'b0, 1'b1, bbc_pkg::ST_MISSING_OPEN, 0,
                               bbc_pkg::CH_LANGLE));
        dir_rows.push_back(row(8'h00, 1'b1));
        dir_rows.push_back(row(bbc_pkg::CH_RBRACE, 1'b0, 1'b1, bbc_pkg::ST_MISSING_OPEN, 0,
                               bbc_pkg::CH_LBRACE));
        dir_rows.push_back(row(8'h00, 1'b1));
        dir_rows.push_back(row(bbc_pkg::CH_LPAREN, 1'b0));
        dir_rows.push_back(row(8'h00, 1'b1, 1'b1, bbc_pkg::ST_MISSING_CLOSE, 1,
                               bbc_pkg::CH_RPAREN));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            push_char(dir_rows[i].ch, dir_rows[i].le, 1'b0, dir_rows[i].fixed,
                      dir_rows[i].want);

        // One opener more than the stack holds.
        repeat (bbc_pkg::STACK_DEPTH + 1)
            push_char(openers[$urandom_range(0, 3)], 1'b0, 1'b0);
        push_char(bbc_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);

        // Lines long enough for the position to saturate: one ends in a stray closer, one with an opener left open.
        repeat (bbc_pkg::MAX_POSITION + 3)
            push_char(pick_filler(), 1'b0, 1'b1);
        push_char(bbc_pkg::CH_RBRACK, 1'b0, 1'b0);
        push_char(bbc_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);
        push_char(bbc_pkg::CH_LPAREN, 1'b0, 1'b0);
        repeat (bbc_pkg::MAX_POSITION + 3)
            push_char(pick_filler(), 1'b0, 1'b1);
        push_char(bbc_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);

        start = counted_beats;
        while (counted_beats - start < RANDOM_ITEMS)
            send_random_line();

        char_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
